### hdl/cmmn_pkg.sv
// Shared constants of the clipped min-max normalizer: register indexes and queue size.
package cmmn_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_LOW  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_HIGH = 1'b1;

    // Entries of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

endpackage

### hdl/clipped_min_max_normalizer.sv
// Path: an accepted item passes the front register, queue, stage 1, stage 2, output register.
// Throughput: one item per cycle when nothing stalls; after the last measure-pass item the
// back part stops popping the queue while its bit-serial divider forms the range reciprocal.
// Items keep entering the queue during that time until it fills.
// Reset: synchronous, active low; clears the clip window to the full range and the frame state.
// Top level of the clipped min-max normalizer.
module clipped_min_max_normalizer #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cmmn_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]             cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample,
    input  logic                                s_not_a_number,
    input  logic                                s_last_of_frame,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic [FRACTION_BITS:0]              m_normalized,
    output logic                                m_pixel_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      m_min_value,
    output logic signed [SAMPLE_WIDTH-1:0]      m_max_value,
    output logic                                m_any_valid
);

    // The front part registers each accepted item, checks it against the clip
    // window and the NaN flag, and pushes it into the queue. The entry carries
    // the pass, the last flag, the classification bit and the raw sample.
    localparam int ENTRY_W = SAMPLE_WIDTH + 3;

    logic               f_valid, f_ready;
    logic [ENTRY_W-1:0] f_data;
    logic               b_valid, b_ready;
    logic [ENTRY_W-1:0] b_data;

    cmmn_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_sample        (s_sample),
        .s_not_a_number  (s_not_a_number),
        .s_last_of_frame (s_last_of_frame),
        .q_valid         (f_valid),
        .q_ready         (f_ready),
        .q_data          (f_data)
    );

    // The queue lets the front keep taking items while the back part waits on
    // the divider or on a stalled result port.
    cmmn_fifo #(.WIDTH(ENTRY_W), .DEPTH(cmmn_pkg::QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    // The back part tracks the running minimum and maximum during the measure
    // pass, emits the summary on its last item and then forms the reciprocal
    // of the range. Normalize-pass items are scaled with one multiply.
    cmmn_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .q_data        (b_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_normalized  (m_normalized),
        .m_pixel_valid (m_pixel_valid),
        .m_min_value   (m_min_value),
        .m_max_value   (m_max_value),
        .m_any_valid   (m_any_valid)
    );

    // A summary item never carries a pixel result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_kind) |-> (!m_pixel_valid && m_normalized == '0))
        else $error("summary item carries a pixel result");

    // Without a valid pixel in the frame the bounds read zero and no pixel is valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_any_valid) |-> (m_min_value == '0 && m_max_value == '0
                                       && !m_pixel_valid))
        else $error("empty frame reports nonzero bounds");

    // A nonzero normalized value only comes from a valid pixel and never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_normalized != '0) |-> (m_pixel_valid && m_kind
            && m_normalized <= {1'b1, {FRACTION_BITS{1'b0}}}))
        else $error("normalized value out of place");

    // Bounds of a frame with a valid pixel are ordered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_any_valid) |-> (m_min_value <= m_max_value))
        else $error("minimum above maximum");

endmodule

### hdl/cmmn_fifo.sv
// Small register queue that decouples the front part from the back part.
module cmmn_fifo #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/cmmn_front.sv
// Front part: clip window registers, item intake and pixel classification.
module cmmn_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cmmn_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]             cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample,
    input  logic                                s_not_a_number,
    input  logic                                s_last_of_frame,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [SAMPLE_WIDTH+2:0]             q_data
);

    localparam int W = SAMPLE_WIDTH;

    logic signed [W-1:0] clip_low_reg, clip_high_reg;
    logic                vld_reg, vld_next;
    logic                mode_reg, last_reg, ok_reg;
    logic [W-1:0]        sample_reg;
    logic                take, in_window;

    assign cfg_ready = 1'b1;
    assign s_ready   = !vld_reg || q_ready;
    assign take      = s_valid && s_ready;
    assign in_window = !s_not_a_number && (s_sample >= clip_low_reg)
                       && (s_sample <= clip_high_reg);

    // Entry layout: mode, last, pixel ok, sample.
    assign q_valid = vld_reg;
    assign q_data  = {mode_reg, last_reg, ok_reg, sample_reg};

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (q_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= 1'b0;
            clip_low_reg  <= {1'b1, {(W-1){1'b0}}};
            clip_high_reg <= {1'b0, {(W-1){1'b1}}};
        end else begin
            vld_reg <= vld_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    cmmn_pkg::CFG_CLIP_LOW:  clip_low_reg  <= $signed(cfg_data);
                    cmmn_pkg::CFG_CLIP_HIGH: clip_high_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
        if (take) begin
            mode_reg   <= s_mode;
            last_reg   <= s_last_of_frame;
            ok_reg     <= in_window;
            sample_reg <= s_sample;
        end
    end

endmodule

### hdl/cmmn_recip_div.sv
// Restoring divider that forms floor(2^W / divisor), one quotient bit per cycle.
module cmmn_recip_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W:0]   quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [W-1:0]     div_reg, rem_reg;
    logic [W:0]       quot_reg;
    logic [W:0]       shifted, trial;
    logic             fits;

    // The dividend is a single one at bit W, fed in on the first step.
    assign shifted = {rem_reg, (cnt_reg == CNT_W'(W))};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            div_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? trial[W-1:0] : shifted[W-1:0];
            quot_reg <= {quot_reg[W-1:0], fits};
        end
    end

endmodule

### hdl/cmmn_back.sv
// Back part: running min and max, range reciprocal and the normalize pipeline.
module cmmn_back #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  logic [SAMPLE_WIDTH+2:0]           q_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [FRACTION_BITS:0]            m_normalized,
    output logic                              m_pixel_valid,
    output logic signed [SAMPLE_WIDTH-1:0]    m_min_value,
    output logic signed [SAMPLE_WIDTH-1:0]    m_max_value,
    output logic                              m_any_valid
);

    localparam int W = SAMPLE_WIDTH;
    localparam int F = FRACTION_BITS;

    typedef enum logic [1:0] {ST_RUN, ST_LAUNCH, ST_DIVIDE} state_t;
    typedef enum logic [1:0] {NC_ZERO, NC_ONE, NC_SCALE} norm_case_t;

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [F:0]          ONE_Q = {1'b1, {F{1'b0}}};

    state_t              state_reg, state_next;
    logic signed [W-1:0] min_reg, min_next, max_reg, max_next;
    logic                found_reg, found_next;
    logic [W:0]          recip_reg, recip_next;

    // Stage 1: classified item.
    logic                p1_vld_reg, p1_vld_next, p1_kind_reg, p1_kind_next;
    norm_case_t          p1_case_reg, p1_case_next;
    logic [W-1:0]        p1_diff_reg, p1_diff_next, p1_recip_reg, p1_recip_next;
    logic                p1_pv_reg, p1_pv_next, p1_any_reg, p1_any_next;
    logic [W-1:0]        p1_min_reg, p1_min_next, p1_max_reg, p1_max_next;
    // Stage 2: product.
    logic                p2_vld_reg, p2_kind_reg, p2_pv_reg, p2_any_reg;
    norm_case_t          p2_case_reg;
    logic [W-1:0]        p2_prod_reg, p2_min_reg, p2_max_reg;
    // Output register.
    logic                out_vld_reg, out_vld_next, out_kind_reg, out_pv_reg, out_any_reg;
    logic [F:0]          out_norm_reg, out_norm_next;
    logic [W-1:0]        out_min_reg, out_max_reg;

    logic signed [W-1:0] x, min_upd, max_upd;
    logic                pix_ok, last, mode, pv;
    logic                advance, pop, div_start, div_done;
    logic [W-1:0]        range, diff;
    logic [W:0]          div_quot;
    logic [2*W-1:0]      mul_full;
    logic [W+F-1:0]      scaled;

    assign x      = $signed(q_data[W-1:0]);
    assign pix_ok = q_data[W];
    assign last   = q_data[W+1];
    assign mode   = q_data[W+2];

    assign advance   = !out_vld_reg || m_ready;
    assign pop       = q_valid && (state_reg == ST_RUN) && advance;
    assign q_ready   = pop;
    assign range     = max_reg - min_reg;
    assign diff      = x - min_reg;
    assign min_upd   = (x < min_reg) ? x : min_reg;
    assign max_upd   = (x > max_reg) ? x : max_reg;
    assign pv        = pix_ok && found_reg;
    assign div_start = (state_reg == ST_LAUNCH) && found_reg && (max_reg > min_reg);
    assign mul_full  = p1_diff_reg * p1_recip_reg;
    assign scaled    = {p2_prod_reg, {F{1'b0}}};

    cmmn_recip_div #(.W(W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (range),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next    = state_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        found_next    = found_reg;
        recip_next    = recip_reg;
        p1_vld_next   = p1_vld_reg;
        p1_kind_next  = p1_kind_reg;
        p1_case_next  = p1_case_reg;
        p1_diff_next  = p1_diff_reg;
        p1_recip_next = p1_recip_reg;
        p1_pv_next    = p1_pv_reg;
        p1_any_next   = p1_any_reg;
        p1_min_next   = p1_min_reg;
        p1_max_next   = p1_max_reg;
        out_vld_next  = out_vld_reg;
        out_norm_next = out_norm_reg;

        if (advance) begin
            p1_vld_next  = 1'b0;
            out_vld_next = p2_vld_reg;
            unique case (p2_case_reg)
                NC_ONE:   out_norm_next = ONE_Q;
                NC_SCALE: out_norm_next = {1'b0, scaled[W+F-1 -: F]};
                default:  out_norm_next = '0;
            endcase
        end

        if (pop) begin
            if (!mode) begin
                if (pix_ok) begin
                    min_next   = min_upd;
                    max_next   = max_upd;
                    found_next = 1'b1;
                end
                p1_vld_next  = last;
                p1_kind_next = 1'b0;
                p1_case_next = NC_ZERO;
                p1_pv_next   = 1'b0;
                p1_any_next  = found_reg || pix_ok;
                p1_min_next  = pix_ok ? min_upd : (found_reg ? min_reg : '0);
                p1_max_next  = pix_ok ? max_upd : (found_reg ? max_reg : '0);
            end else begin
                p1_vld_next   = 1'b1;
                p1_kind_next  = 1'b1;
                p1_pv_next    = pv;
                p1_any_next   = found_reg;
                p1_min_next   = found_reg ? min_reg : '0;
                p1_max_next   = found_reg ? max_reg : '0;
                p1_diff_next  = diff;
                p1_recip_next = recip_reg[W-1:0];
                priority if (!pv || recip_reg == '0) begin
                    p1_case_next = NC_ZERO;
                end else if (x >= max_reg) begin
                    p1_case_next = NC_ONE;
                end else if (x > min_reg) begin
                    p1_case_next = NC_SCALE;
                end else begin
                    p1_case_next = NC_ZERO;
                end
                if (last) begin
                    min_next   = SMAX;
                    max_next   = SMIN;
                    found_next = 1'b0;
                    recip_next = '0;
                end
            end
        end

        unique case (state_reg)
            ST_RUN: begin
                if (pop && !mode && last) begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                if (div_start) begin
                    state_next = ST_DIVIDE;
                end else begin
                    recip_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    recip_next = div_quot;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            min_reg     <= SMAX;
            max_reg     <= SMIN;
            found_reg   <= 1'b0;
            recip_reg   <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            found_reg   <= found_next;
            recip_reg   <= recip_next;
            p1_vld_reg  <= p1_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                p2_vld_reg <= p1_vld_reg;
            end
        end
        p1_kind_reg  <= p1_kind_next;
        p1_case_reg  <= p1_case_next;
        p1_diff_reg  <= p1_diff_next;
        p1_recip_reg <= p1_recip_next;
        p1_pv_reg    <= p1_pv_next;
        p1_any_reg   <= p1_any_next;
        p1_min_reg   <= p1_min_next;
        p1_max_reg   <= p1_max_next;
        out_norm_reg <= out_norm_next;
        if (advance) begin
            p2_kind_reg  <= p1_kind_reg;
            p2_case_reg  <= p1_case_reg;
            p2_prod_reg  <= mul_full[W-1:0];
            p2_pv_reg    <= p1_pv_reg;
            p2_any_reg   <= p1_any_reg;
            p2_min_reg   <= p1_min_reg;
            p2_max_reg   <= p1_max_reg;
            out_kind_reg <= p2_kind_reg;
            out_pv_reg   <= p2_pv_reg;
            out_any_reg  <= p2_any_reg;
            out_min_reg  <= p2_min_reg;
            out_max_reg  <= p2_max_reg;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_kind        = out_kind_reg;
    assign m_normalized  = out_norm_reg;
    assign m_pixel_valid = out_pv_reg;
    assign m_min_value   = $signed(out_min_reg);
    assign m_max_value   = $signed(out_max_reg);
    assign m_any_valid   = out_any_reg;

endmodule
